// File: hw/rtl/wsts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wsts_pkg: shared types and constants of the weighted sum-tree sampler
// Sizes of the node store, entry layout, codes of the sequencer and of the
// shared arithmetic unit.
// ============================================================================
package wsts_pkg;

   // Store sizing
   localparam int MAX_NODES   = 1024;
   localparam int WEIGHT_BITS = 32;
   localparam int INDEX_BITS  = $clog2(MAX_NODES);
   localparam int COUNT_BITS  = $clog2(MAX_NODES + 1);
   // Child indexes reach 2 * MAX_NODES
   localparam int CHILD_BITS  = $clog2(2 * MAX_NODES + 1);
   localparam int NUM_TREES   = 2;

   // Fixed field widths
   localparam int TOTAL_BITS  = 42;
   localparam int FRAC_BITS   = 32;
   localparam int MUL_BITS    = 32;
   localparam int LO_BITS     = MUL_BITS;
   localparam int STATUS_BITS = 2;

   // One tree's view of a node
   typedef struct packed {
      logic [WEIGHT_BITS-1:0] own;
      logic [TOTAL_BITS-1:0]  sub;
   } node_type;

   // Store entry: lane 0 source tree, lane 1 target tree
   typedef node_type [NUM_TREES-1:0] entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef logic [NUM_TREES-1:0][TOTAL_BITS-1:0]  lanes_type;
   typedef logic [NUM_TREES-1:0][WEIGHT_BITS-1:0] weights_type;

   // Request kinds
   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_kind_type;

   // Response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Shared unit operations
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Shared unit results
   typedef struct packed {
      lanes_type                 sum;
      logic [NUM_TREES-1:0]      borrow;
      logic [2*MUL_BITS-1:0]     product;
   } alu_res_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_LOAD,
      S_UP_ADD,
      S_MUL_LO,
      S_MUL_HI,
      S_CUT_SUM,
      S_DN_READ,
      S_DN_CLAMP,
      S_DN_OWN,
      S_DN_LEFT,
      S_DONE
   } state_type;

endpackage

// File: hw/rtl/wsts_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// wsts_ram: generic memory, one write port, two registered read ports
// Read data is registered and appears in the cycle after the address; no reset of the contents.
// ============================================================================
module wsts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_a,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: hw/rtl/wsts_alu.sv
`timescale 1ns / 1ps
// ============================================================================
// wsts_alu: shared arithmetic unit of the sampler
// Two lanes of add or subtract with borrow out, plus one 32 x 32 multiplier.
// ============================================================================
module wsts_alu (
   input  wsts_pkg::alu_op_type          alu_op,
   input  wsts_pkg::lanes_type           alu_a,
   input  wsts_pkg::lanes_type           alu_b,
   input  logic [wsts_pkg::MUL_BITS-1:0] mul_a,
   input  logic [wsts_pkg::MUL_BITS-1:0] mul_b,
   output wsts_pkg::alu_res_type         alu_res
);

   logic [wsts_pkg::NUM_TREES-1:0][wsts_pkg::TOTAL_BITS:0] wide;

   // Add or subtract per lane; top bit is the borrow on subtract
   always_comb begin
      for (int i = 0; i < wsts_pkg::NUM_TREES; i++) begin
         if (alu_op == wsts_pkg::ALU_SUB) begin
            wide[i] = {1'b0, alu_a[i]} - {1'b0, alu_b[i]};
         end else begin
            wide[i] = {1'b0, alu_a[i]} + {1'b0, alu_b[i]};
         end
         alu_res.sum[i]    = wide[i][wsts_pkg::TOTAL_BITS-1:0];
         alu_res.borrow[i] = wide[i][wsts_pkg::TOTAL_BITS];
      end
      alu_res.product = (2 * wsts_pkg::MUL_BITS)'(mul_a) * (2 * wsts_pkg::MUL_BITS)'(mul_b);
   end

endmodule

// File: hw/rtl/weighted_sum_tree_sampler.sv
`timescale 1ns / 1ps
// A write reads, sums and writes back each node on the path from the node to the root
//   (1 to 11 nodes); a sample forms the cutoff, then descends the chosen tree (up to 10
//   levels) to the chosen node; rejected requests go straight to the done state.
// Throughput: one transaction at a time, set by the single shared adder lane pair and
//   the one-entry-per-port node memory; req_stall holds off new requests until idle.
// Reset: synchronous; the node count and root totals clear at once, no memory sweep.
// ============================================================================
// weighted_sum_tree_sampler: source and target sum trees with weighted draw
// Updates node weights with a path refresh to the root and samples a node by
// descending the chosen tree with a scaled cutoff, all on one shared unit.
// ============================================================================
module weighted_sum_tree_sampler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_req_type,
   input  logic [wsts_pkg::INDEX_BITS-1:0]    req_node_index,
   input  logic [wsts_pkg::WEIGHT_BITS-1:0]   req_source_weight,
   input  logic [wsts_pkg::WEIGHT_BITS-1:0]   req_target_weight,
   input  logic                               req_tree_select,
   input  logic [wsts_pkg::FRAC_BITS-1:0]     req_cutoff_fraction,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [wsts_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [wsts_pkg::INDEX_BITS-1:0]    rsp_chosen_node,
   output logic [wsts_pkg::TOTAL_BITS-1:0]    rsp_root_total,
   output logic [wsts_pkg::COUNT_BITS-1:0]    rsp_node_total
);

   // Left child index of a node
   function automatic logic [wsts_pkg::CHILD_BITS-1:0] left_child(
      input logic [wsts_pkg::INDEX_BITS-1:0] n
   );
      return (wsts_pkg::CHILD_BITS'(n) << 1) + wsts_pkg::CHILD_BITS'(1);
   endfunction

   // Control registers
   wsts_pkg::state_type                  state_ff, state_in;
   logic [wsts_pkg::COUNT_BITS-1:0]      count_ff, count_in;
   wsts_pkg::lanes_type                  root_ff, root_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic                                 tsel_ff, tsel_in;
   logic [wsts_pkg::FRAC_BITS-1:0]       frac_ff, frac_in;
   logic [wsts_pkg::INDEX_BITS-1:0]      n_ff, n_in;
   logic [wsts_pkg::CHILD_BITS-1:0]      a_idx_ff, a_idx_in;
   logic [wsts_pkg::CHILD_BITS-1:0]      b_idx_ff, b_idx_in;
   logic                                 first_ff, first_in;
   wsts_pkg::weights_type                own_ff, own_in;
   wsts_pkg::lanes_type                  acc_ff, acc_in;
   logic [wsts_pkg::TOTAL_BITS-1:0]      w_ff, w_in;
   logic [2*wsts_pkg::MUL_BITS-1:0]      prod_ff, prod_in;
   wsts_pkg::status_type                 status_ff, status_in;
   logic [wsts_pkg::INDEX_BITS-1:0]      chosen_ff, chosen_in;
   wsts_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [wsts_pkg::INDEX_BITS-1:0]      rsp_chosen_ff, rsp_chosen_in;
   logic [wsts_pkg::TOTAL_BITS-1:0]      rsp_root_ff, rsp_root_in;
   logic [wsts_pkg::COUNT_BITS-1:0]      rsp_count_ff, rsp_count_in;

   // Memory and shared unit
   logic                                 ram_wr_en;
   wsts_pkg::entry_type                  ram_wr_data;
   wsts_pkg::entry_type                  rd_a;
   wsts_pkg::entry_type                  rd_b;
   wsts_pkg::alu_op_type                 alu_op;
   wsts_pkg::lanes_type                  alu_a;
   wsts_pkg::lanes_type                  alu_b;
   logic [wsts_pkg::MUL_BITS-1:0]        mul_a;
   logic [wsts_pkg::MUL_BITS-1:0]        mul_b;
   wsts_pkg::alu_res_type                alu_res;

   // Derived decode
   logic [wsts_pkg::CHILD_BITS-1:0]      count_wide;
   logic                                 a_ok;
   logic                                 b_ok;
   logic [wsts_pkg::CHILD_BITS-1:0]      right_idx;
   logic                                 right_ok;
   logic [wsts_pkg::COUNT_BITS-1:0]      idx_ext;
   logic                                 req_in_range;
   logic                                 req_append;
   wsts_pkg::node_type                   sel_a;
   wsts_pkg::node_type                   sel_b;
   logic                                 rsp_free;

   wsts_ram #(
      .WIDTH (wsts_pkg::ENTRY_BITS),
      .DEPTH (wsts_pkg::MAX_NODES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (n_ff),
      .wr_data   (ram_wr_data),
      .rd_addr_a (a_idx_ff[wsts_pkg::INDEX_BITS-1:0]),
      .rd_addr_b (b_idx_ff[wsts_pkg::INDEX_BITS-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   wsts_alu u_alu (
      .alu_op  (alu_op),
      .alu_a   (alu_a),
      .alu_b   (alu_b),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .alu_res (alu_res)
   );

   // Decode child presence and request range
   assign count_wide   = wsts_pkg::CHILD_BITS'(count_ff);
   assign a_ok         = a_idx_ff < count_wide;
   assign b_ok         = b_idx_ff < count_wide;
   assign right_idx    = b_idx_ff + wsts_pkg::CHILD_BITS'(1);
   assign right_ok     = right_idx < count_wide;
   assign idx_ext      = wsts_pkg::COUNT_BITS'(req_node_index);
   assign req_in_range = idx_ext < count_ff;
   assign req_append   = (idx_ext == count_ff) &&
                         (count_ff < wsts_pkg::COUNT_BITS'(wsts_pkg::MAX_NODES));
   assign sel_a        = rd_a[tsel_ff];
   assign sel_b        = rd_b[tsel_ff];
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // Hold off new transactions while one is in flight
   assign req_stall    = (state_ff != wsts_pkg::S_IDLE);

   // Write back the refreshed node with the running sums
   always_comb begin
      for (int i = 0; i < wsts_pkg::NUM_TREES; i++) begin
         ram_wr_data[i].own = own_ff[i];
         ram_wr_data[i].sub = alu_res.sum[i];
      end
   end

   // Sequencer: next state, datapath control and next register values
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      root_in       = root_ff;
      rsp_valid_in  = rsp_valid_ff;
      tsel_in       = tsel_ff;
      frac_in       = frac_ff;
      n_in          = n_ff;
      a_idx_in      = a_idx_ff;
      b_idx_in      = b_idx_ff;
      first_in      = first_ff;
      own_in        = own_ff;
      acc_in        = acc_ff;
      w_in          = w_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      chosen_in     = chosen_ff;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      alu_op        = wsts_pkg::ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;
      mul_a         = '0;
      mul_b         = frac_ff;

      // Drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         wsts_pkg::S_IDLE: begin
            if (req_valid) begin
               tsel_in   = req_tree_select;
               frac_in   = req_cutoff_fraction;
               status_in = wsts_pkg::STATUS_OK;
               chosen_in = '0;
               if (req_req_type == wsts_pkg::REQ_SAMPLE) begin
                  if (root_ff[req_tree_select] == '0) begin
                     status_in = wsts_pkg::STATUS_EMPTY;
                     state_in  = wsts_pkg::S_DONE;
                  end else begin
                     state_in  = wsts_pkg::S_MUL_LO;
                  end
               end else if (req_in_range || req_append) begin
                  if (req_append) begin
                     count_in = count_ff + wsts_pkg::COUNT_BITS'(1);
                  end
                  n_in      = req_node_index;
                  a_idx_in  = left_child(req_node_index);
                  b_idx_in  = left_child(req_node_index) + wsts_pkg::CHILD_BITS'(1);
                  first_in  = 1'b1;
                  own_in[0] = req_source_weight;
                  own_in[1] = req_target_weight;
                  state_in  = wsts_pkg::S_UP_READ;
               end else begin
                  status_in = wsts_pkg::STATUS_RANGE;
                  state_in  = wsts_pkg::S_DONE;
               end
            end
         end

         // Wait for the node and child reads
         wsts_pkg::S_UP_READ: begin
            state_in = wsts_pkg::S_UP_LOAD;
         end

         // First add: own weight plus left child, or carried child total
         wsts_pkg::S_UP_LOAD: begin
            for (int i = 0; i < wsts_pkg::NUM_TREES; i++) begin
               if (first_ff) begin
                  alu_a[i] = wsts_pkg::TOTAL_BITS'(own_ff[i]);
                  alu_b[i] = a_ok ? rd_a[i].sub : '0;
               end else begin
                  alu_a[i]  = wsts_pkg::TOTAL_BITS'(rd_a[i].own);
                  alu_b[i]  = acc_ff[i];
                  own_in[i] = rd_a[i].own;
               end
            end
            acc_in   = alu_res.sum;
            state_in = wsts_pkg::S_UP_ADD;
         end

         // Second add, write the node, advance to the parent
         wsts_pkg::S_UP_ADD: begin
            for (int i = 0; i < wsts_pkg::NUM_TREES; i++) begin
               alu_a[i] = acc_ff[i];
               alu_b[i] = b_ok ? rd_b[i].sub : '0;
            end
            ram_wr_en = 1'b1;
            acc_in    = alu_res.sum;
            first_in  = 1'b0;
            if (n_ff == '0) begin
               root_in  = alu_res.sum;
               state_in = wsts_pkg::S_DONE;
            end else begin
               n_in     = (n_ff - wsts_pkg::INDEX_BITS'(1)) >> 1;
               a_idx_in = wsts_pkg::CHILD_BITS'((n_ff - wsts_pkg::INDEX_BITS'(1)) >> 1);
               if (n_ff[0]) begin
                  b_idx_in = wsts_pkg::CHILD_BITS'(n_ff) + wsts_pkg::CHILD_BITS'(1);
               end else begin
                  b_idx_in = wsts_pkg::CHILD_BITS'(n_ff) - wsts_pkg::CHILD_BITS'(1);
               end
               state_in = wsts_pkg::S_UP_READ;
            end
         end

         // Low half of the total times the fraction
         wsts_pkg::S_MUL_LO: begin
            mul_a    = root_ff[tsel_ff][wsts_pkg::LO_BITS-1:0];
            prod_in  = alu_res.product;
            state_in = wsts_pkg::S_MUL_HI;
         end

         // Keep the carried high word, multiply the high part
         wsts_pkg::S_MUL_HI: begin
            mul_a    = wsts_pkg::MUL_BITS'(
                          root_ff[tsel_ff][wsts_pkg::TOTAL_BITS-1:wsts_pkg::LO_BITS]);
            w_in     = wsts_pkg::TOTAL_BITS'(
                          prod_ff[2*wsts_pkg::MUL_BITS-1:wsts_pkg::MUL_BITS]);
            prod_in  = alu_res.product;
            state_in = wsts_pkg::S_CUT_SUM;
         end

         // Form the cutoff and start at the root
         wsts_pkg::S_CUT_SUM: begin
            alu_a[0] = prod_ff[wsts_pkg::TOTAL_BITS-1:0];
            alu_b[0] = w_ff;
            w_in     = alu_res.sum[0];
            n_in     = '0;
            a_idx_in = '0;
            b_idx_in = left_child('0);
            state_in = wsts_pkg::S_DN_READ;
         end

         // Wait for the node and left child reads
         wsts_pkg::S_DN_READ: begin
            state_in = wsts_pkg::S_DN_CLAMP;
         end

         // Clamp the cutoff to the subtree total
         wsts_pkg::S_DN_CLAMP: begin
            alu_op   = wsts_pkg::ALU_SUB;
            alu_a[0] = sel_a.sub;
            alu_b[0] = w_ff;
            if (alu_res.borrow[0]) begin
               w_in = sel_a.sub;
            end
            state_in = wsts_pkg::S_DN_OWN;
         end

         // Pick this node if the cutoff falls in its own weight
         wsts_pkg::S_DN_OWN: begin
            alu_op   = wsts_pkg::ALU_SUB;
            alu_a[0] = w_ff;
            alu_b[0] = wsts_pkg::TOTAL_BITS'(sel_a.own);
            if (alu_res.borrow[0] || (alu_res.sum[0] == '0)) begin
               chosen_in = n_ff;
               state_in  = wsts_pkg::S_DONE;
            end else begin
               w_in     = alu_res.sum[0];
               state_in = wsts_pkg::S_DN_LEFT;
            end
         end

         // Go right past the left total, else left; stop at a missing child
         wsts_pkg::S_DN_LEFT: begin
            alu_op   = wsts_pkg::ALU_SUB;
            alu_a[0] = w_ff;
            alu_b[0] = b_ok ? sel_b.sub : '0;
            if (!alu_res.borrow[0] && (alu_res.sum[0] != '0)) begin
               if (!right_ok) begin
                  chosen_in = n_ff;
                  state_in  = wsts_pkg::S_DONE;
               end else begin
                  w_in     = alu_res.sum[0];
                  n_in     = right_idx[wsts_pkg::INDEX_BITS-1:0];
                  a_idx_in = right_idx;
                  b_idx_in = left_child(right_idx[wsts_pkg::INDEX_BITS-1:0]);
                  state_in = wsts_pkg::S_DN_READ;
               end
            end else if (!b_ok) begin
               chosen_in = n_ff;
               state_in  = wsts_pkg::S_DONE;
            end else begin
               n_in     = b_idx_ff[wsts_pkg::INDEX_BITS-1:0];
               a_idx_in = b_idx_ff;
               b_idx_in = left_child(b_idx_ff[wsts_pkg::INDEX_BITS-1:0]);
               state_in = wsts_pkg::S_DN_READ;
            end
         end

         // Load the response register once it is free
         wsts_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_chosen_in = chosen_ff;
               rsp_root_in   = root_ff[tsel_ff];
               rsp_count_in  = count_ff;
               state_in      = wsts_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wsts_pkg::S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         root_ff      <= root_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tsel_ff       <= tsel_in;
      frac_ff       <= frac_in;
      n_ff          <= n_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      first_ff      <= first_in;
      own_ff        <= own_in;
      acc_ff        <= acc_in;
      w_ff          <= w_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      chosen_ff     <= chosen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_node = rsp_chosen_ff;
   assign rsp_root_total  = rsp_root_ff;
   assign rsp_node_total  = rsp_count_ff;

endmodule
